>>> src/kps_pkg.sv
// Package for the matrix keypad scanner: transaction structs, opcodes, phases,
// status codes, register indexes and configuration defaults. No dependencies.
`default_nettype none

package kps_pkg;

  localparam int ROWS = 4;
  localparam int COLS = 4;
  localparam int ROW_W = 2;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS   = 2'd2;

  localparam logic [7:0] TICKS_PER_STEP_RST = 8'd10;
  localparam logic [7:0] RELEASE_LIMIT_RST  = 8'd40;
  localparam logic [3:0] SETTLE_TICKS_RST   = 4'd1;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TICK   = 2'd2
  } kps_op_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRECHECK = 3'd1,
    PH_SCAN     = 3'd2,
    PH_RELEASE  = 3'd3,
    PH_SETTLE   = 3'd4
  } kps_phase_e;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_HELD    = 2'd2
  } kps_status_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] timeout_steps;
    logic       beep_enable;
    logic [3:0] columns;
  } kps_in_t;

  typedef struct packed {
    logic [1:0] row_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [2:0] key_row;
    logic [2:0] key_column;
    logic       beep;
  } kps_out_t;

  typedef struct packed {
    logic [7:0] ticks_per_step;
    logic [7:0] release_limit;
    logic [3:0] settle_ticks;
  } kps_cfg_t;

endpackage

`default_nettype wire

>>> src/kps_cfg.sv
// Configuration register file of the keypad scanner: three write-only registers.
// Depends on kps_pkg.
`default_nettype none

module kps_cfg
  import kps_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output kps_cfg_t                   cfg_o
);

  kps_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TICKS_PER_STEP: cfg_d.ticks_per_step = cfg_data_i;
        REG_RELEASE_LIMIT:  cfg_d.release_limit  = cfg_data_i;
        REG_SETTLE_TICKS:   cfg_d.settle_ticks   = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_step <= TICKS_PER_STEP_RST;
      cfg_q.release_limit  <= RELEASE_LIMIT_RST;
      cfg_q.settle_ticks   <= SETTLE_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> src/kps_core.sv
// Scan state and per-transaction step logic: phase, row counter, tick timer,
// latched call options; produces one result per advanced item. Depends on kps_pkg.
`default_nettype none

module kps_core
  import kps_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire kps_in_t  item_i,
  input  wire kps_cfg_t cfg_i,
  output kps_out_t      res_o
);

  localparam logic [COLS-1:0] COL_ALL = {COLS{1'b1}};

  kps_phase_e  phase_q, phase_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [15:0] timer_q, timer_d;
  logic        single_q, single_d;
  logic [2:0]  frow_q, frow_d;
  logic [2:0]  fcol_q, fcol_d;
  logic        beep_q, beep_d;
  logic [7:0]  tmo_q, tmo_d;

  logic [COLS-1:0] cols;
  logic [COLS-1:0] low;
  logic [2:0]      col_num;
  logic [15:0]     timer_dec;
  logic [15:0]     step_prod;
  logic            row_last;
  logic            done;
  kps_status_e     st;
  logic            bp;
  logic            busy;

  assign cols      = item_i.columns[COLS-1:0];
  assign low       = ~cols;
  assign timer_dec = (timer_q != 16'd0) ? (timer_q - 16'd1) : 16'd0;
  assign step_prod = 16'(cfg_i.ticks_per_step) * 16'(tmo_q);
  assign row_last  = (row_q == ROW_W'(ROWS - 1));

  // Topmost column (highest bit) wins
  always_comb begin
    col_num = 3'd0;
    for (int i = 0; i < COLS; i++) begin
      if (low[i]) col_num = 3'(COLS - i);
    end
  end

  always_comb begin
    phase_d  = phase_q;
    row_d    = row_q;
    timer_d  = timer_q;
    single_d = single_q;
    frow_d   = frow_q;
    fcol_d   = fcol_q;
    beep_d   = beep_q;
    tmo_d    = tmo_q;
    done     = 1'b0;
    st       = ST_FOUND;
    bp       = 1'b0;
    case (kps_op_e'(item_i.opcode))
      OP_START: begin
        tmo_d   = item_i.timeout_steps;
        beep_d  = item_i.beep_enable;
        frow_d  = 3'd0;
        fcol_d  = 3'd0;
        row_d   = '0;
        timer_d = 16'd0;
        if (item_i.timeout_steps != 8'd0) begin
          single_d = 1'b0;
          phase_d  = PH_PRECHECK;
        end else begin
          single_d = 1'b1;
          phase_d  = PH_SCAN;
        end
      end
      OP_SAMPLE: begin
        case (phase_q)
          PH_PRECHECK: begin
            if (cols != COL_ALL) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              st      = ST_HELD;
            end else if (row_last) begin
              phase_d = PH_SCAN;
              row_d   = '0;
              if (!single_q) timer_d = step_prod;
            end else begin
              row_d = row_q + 1'b1;
            end
          end
          PH_SCAN: begin
            if (low != '0) begin
              frow_d = 3'(row_q) + 3'd1;
              fcol_d = col_num;
              bp     = beep_q;
              if (cfg_i.release_limit == 8'd0) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
                st      = ST_HELD;
              end else begin
                phase_d = PH_RELEASE;
                timer_d = 16'(cfg_i.release_limit);
              end
            end else if (row_last) begin
              row_d = '0;
              if (single_q || timer_q == 16'd0) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
                st      = ST_TIMEOUT;
              end
            end else begin
              row_d = row_q + 1'b1;
            end
          end
          PH_RELEASE: begin
            if (cols == COL_ALL) begin
              if (cfg_i.settle_ticks == 4'd0) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
                st      = ST_FOUND;
              end else begin
                phase_d = PH_SETTLE;
                timer_d = 16'(cfg_i.settle_ticks);
              end
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        case (phase_q)
          PH_SCAN: timer_d = timer_dec;
          PH_RELEASE: begin
            timer_d = timer_dec;
            if (timer_dec == 16'd0) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              st      = ST_HELD;
            end
          end
          PH_SETTLE: begin
            timer_d = timer_dec;
            if (timer_dec == 16'd0) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              st      = ST_FOUND;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    busy             = (phase_d != PH_IDLE);
    res_o.row_drive  = busy ? row_d : '0;
    res_o.busy_res   = busy;
    res_o.done_res   = done;
    res_o.status     = done ? st : ST_FOUND;
    res_o.key_row    = (done && st == ST_FOUND) ? frow_d : 3'd0;
    res_o.key_column = (done && st == ST_FOUND) ? fcol_d : 3'd0;
    res_o.beep       = bp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      row_q    <= '0;
      timer_q  <= 16'd0;
      single_q <= 1'b0;
      frow_q   <= 3'd0;
      fcol_q   <= 3'd0;
      beep_q   <= 1'b0;
      tmo_q    <= 8'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      row_q    <= row_d;
      timer_q  <= timer_d;
      single_q <= single_d;
      frow_q   <= frow_d;
      fcol_q   <= fcol_d;
      beep_q   <= beep_d;
      tmo_q    <= tmo_d;
    end
  end

endmodule

`default_nettype wire

>>> src/matrix_keypad_scanner_unit.sv
// Matrix keypad scanner, 4x4 key matrix.
// Channels: in_* carries request/sample/tick transactions (valid/ready),
// out_* returns exactly one result transaction per input transaction, in order.
// cfg_* is a write-only register port (ticks_per_step, release_limit,
// settle_ticks), written without handshake; write it only while no call runs.
// Path: an accepted transaction passes the input register, then the step
// logic into the output register, which presents its result on out_*.
// Throughput: 1 transaction per cycle while the receiver keeps up; each
// transaction is one start request, one row sample or one tick, settled
// by one compare/count step in the core.
// The sustained rate is bounded only by the receiver: when out_ready_i is low
// the output register holds, the input register fills, and in_ready_o drops
// until the held result is taken.
// Reset: asynchronous, active low; phase goes idle, counters and latched
// options clear, registers return to 10, 40 and 1.
// Depends on kps_pkg, kps_cfg, kps_core.
`default_nettype none

module matrix_keypad_scanner_unit
  import kps_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire kps_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output kps_out_t                   out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  kps_cfg_t cfg;
  kps_out_t res;

  logic     in_valid_q;
  kps_in_t  in_data_q;
  logic     out_valid_q;
  kps_out_t out_data_q;
  logic     advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  kps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  kps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> src/kps_checker.sv
// Port-level checker for the keypad scanner result channel, bound to the top.
// Depends on kps_pkg and matrix_keypad_scanner_unit.
`default_nettype none

module kps_checker
  import kps_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire kps_out_t out_data_o
);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("finished transaction still shows busy");

  a_key_only_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.key_row != 3'd0 || out_data_o.key_column != 3'd0)
    |-> out_data_o.done_res && out_data_o.status == ST_FOUND)
    else $error("key reported without found status");

  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.status == ST_FOUND)
    else $error("status set without done");

  a_idle_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.busy_res |-> out_data_o.row_drive == 2'd0)
    else $error("row driven while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind matrix_keypad_scanner_unit kps_checker u_kps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
